// File: rtl/core/telnet_option_responder_top_assert.svh
// Assertion macros for the telnet option responder checker.
`ifndef TELNET_OPTION_RESPONDER_TOP_ASSERT_SVH
`define TELNET_OPTION_RESPONDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TOR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("telnet option responder: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TOR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("telnet option responder: check failed");

`endif

// File: rtl/core/telopt_pkg.sv
package telopt_pkg;

    localparam logic [7:0] IAC_BYTE  = 8'd255;
    localparam logic [7:0] CMD_WILL  = 8'd251;
    localparam logic [7:0] CMD_WONT  = 8'd252;
    localparam logic [7:0] CMD_DO    = 8'd253;
    localparam logic [7:0] CMD_DONT  = 8'd254;
    localparam logic [7:0] CMD_SB    = 8'd250;
    localparam logic [7:0] CMD_SE    = 8'd240;
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_TTYPE = 8'd24;

    localparam int unsigned TTYPE_LEN = 10;
    localparam int unsigned IDX_W     = $clog2(TTYPE_LEN);
    localparam logic [IDX_W-1:0] TRIPLE_LAST = IDX_W'(2);
    localparam logic [IDX_W-1:0] TTYPE_LAST  = IDX_W'(TTYPE_LEN - 1);

    typedef enum logic [1:0] {
        PH_DATA = 2'd0,
        PH_CMD  = 2'd1,
        PH_OPT  = 2'd2,
        PH_SKIP = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        JOB_PASS   = 2'd0,
        JOB_TRIPLE = 2'd1,
        JOB_TTYPE  = 2'd2
    } job_kind_t;

    // Terminal type reply: IAC SB TTYPE IS "ANSI" IAC SE
    function automatic logic [7:0] ttype_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            IDX_W'(0): b = IAC_BYTE;
            IDX_W'(1): b = CMD_SB;
            IDX_W'(2): b = OPT_TTYPE;
            IDX_W'(3): b = 8'd0;
            IDX_W'(4): b = 8'd65;
            IDX_W'(5): b = 8'd78;
            IDX_W'(6): b = 8'd83;
            IDX_W'(7): b = 8'd73;
            IDX_W'(8): b = IAC_BYTE;
            IDX_W'(9): b = CMD_SE;
            default:   b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/telnet_option_responder_top.sv
// Channel | Handshake            | Payload
// --------+----------------------+------------------------------
// in      | in_valid / in_ready  | in_byte
// out     | out_valid / out_ready| out_byte, to_remote, last
//
// An input byte is decoded in the cycle it is accepted; its results show
// from the job register on the next cycle, one byte per cycle with out_ready
// high. A passed data byte or a consumed command byte allows a new item
// every cycle while out_ready is high. A three-byte or terminal type reply
// holds in_ready low until its last byte is taken. rst_n clears the decoder
// state and the job's busy, kind and index asynchronously, not data or verb.
module telnet_option_responder_top
    import telopt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       to_remote,
    output logic       last
);

    // Decoder state
    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;

    // Job register: one pending reply or passed byte
    logic             busy_reg, busy_next;
    job_kind_t        kind_reg, kind_next;
    logic [7:0]       data_reg, data_next;
    logic [7:0]       verb_reg, verb_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Decode of the current input byte
    logic       job_start;
    job_kind_t  job_kind;
    logic [7:0] job_verb;

    logic in_fire;
    logic out_fire;
    logic is_will_wont;
    logic is_do;
    logic opt_accept_do;
    logic opt_accept_will;

    // Take the next item when the job register is free or drains now.
    assign in_ready  = !busy_reg || (out_ready && last);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    assign is_will_wont    = (held_reg == CMD_WILL) || (held_reg == CMD_WONT);
    assign is_do           = (held_reg == CMD_DO);
    assign opt_accept_do   = (in_byte == OPT_SGA) || (in_byte == OPT_TTYPE);
    assign opt_accept_will = opt_accept_do || (in_byte == OPT_ECHO);

    // Next phase and held command
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (in_fire)
        begin
            case (phase_reg)
                PH_DATA:
                begin
                    if (in_byte == IAC_BYTE)
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    held_next  = in_byte;
                    phase_next = PH_OPT;
                end
                PH_OPT:
                begin
                    // An SB not closed at once keeps skipping until SE.
                    if ((held_reg == CMD_SB) && (in_byte != CMD_SE))
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_SKIP:
                begin
                    if (in_byte == CMD_SE)
                    begin
                        phase_next = PH_DATA;
                    end
                end
                default:
                begin
                    phase_next = PH_DATA;
                end
            endcase
        end
    end

    // Reply selection for the byte at the input
    always_comb
    begin
        job_start = 1'b0;
        job_kind  = JOB_PASS;
        job_verb  = CMD_WILL;
        case (phase_reg)
            PH_DATA:
            begin
                job_start = (in_byte != IAC_BYTE);
            end
            PH_CMD:
            begin
                job_start = 1'b0;
            end
            PH_OPT:
            begin
                job_kind = JOB_TRIPLE;
                if (is_do && opt_accept_do)
                begin
                    job_start = 1'b1;
                    job_verb  = CMD_WILL;
                end
                else if (is_will_wont && opt_accept_will)
                begin
                    job_start = 1'b1;
                    job_verb  = CMD_DO;
                end
                else if (is_will_wont)
                begin
                    job_start = 1'b1;
                    job_verb  = CMD_DONT;
                end
                else if (is_do || (held_reg == CMD_DONT))
                begin
                    job_start = 1'b1;
                    job_verb  = CMD_WONT;
                end
                else if ((held_reg == CMD_SB) && (in_byte == CMD_SE))
                begin
                    job_start = 1'b1;
                    job_kind  = JOB_TTYPE;
                end
            end
            PH_SKIP:
            begin
                job_kind  = JOB_TTYPE;
                job_start = (in_byte == CMD_SE);
            end
            default:
            begin
                job_start = 1'b0;
            end
        endcase
    end

    // Job register: load on a new job, advance per byte taken, drop at end.
    always_comb
    begin
        busy_next = busy_reg;
        kind_next = kind_reg;
        data_next = data_reg;
        verb_next = verb_reg;
        idx_next  = idx_reg;
        if (out_fire)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
        if (in_fire && job_start)
        begin
            busy_next = 1'b1;
            kind_next = job_kind;
            data_next = in_byte;
            verb_next = job_verb;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DATA;
            held_reg  <= 8'd0;
            busy_reg  <= 1'b0;
            kind_reg  <= JOB_PASS;
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            busy_reg  <= busy_next;
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        verb_reg <= verb_next;
    end

    // Output byte select from the job register
    always_comb
    begin
        out_byte  = data_reg;
        to_remote = 1'b1;
        last      = 1'b1;
        case (kind_reg)
            JOB_PASS:
            begin
                out_byte  = data_reg;
                to_remote = 1'b0;
                last      = 1'b1;
            end
            JOB_TRIPLE:
            begin
                last = (idx_reg == TRIPLE_LAST);
                if (idx_reg == IDX_W'(0))
                begin
                    out_byte = IAC_BYTE;
                end
                else if (idx_reg == IDX_W'(1))
                begin
                    out_byte = verb_reg;
                end
                else
                begin
                    out_byte = data_reg;
                end
            end
            JOB_TTYPE:
            begin
                out_byte = ttype_byte(idx_reg);
                last     = (idx_reg == TTYPE_LAST);
            end
            default:
            begin
                out_byte = data_reg;
            end
        endcase
    end

    assign out_valid = busy_reg;

endmodule

// File: rtl/core/telopt_checker.sv
`include "telnet_option_responder_top_assert.svh"

module telopt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       to_remote,
    input logic       last
);

    // A stalled result holds its byte.
    `TOR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))

    // A byte for the terminal always stands alone.
    `TOR_ASSERT_NOW(a_local_single, out_valid && !to_remote, last)

    // A reply runs without gaps once started.
    `TOR_ASSERT_NEXT(a_reply_no_gap, out_valid && out_ready && !last, out_valid && to_remote)

    // Input is open whenever nothing waits at the output.
    `TOR_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind telnet_option_responder_top telopt_checker u_telopt_checker (.*);

// File: dv/testbench.sv
module testbench;
    import telopt_pkg::*;

    // One byte that the block hands out: data byte, its destination and the
    // end-of-reply flag.
    typedef struct packed {
        logic [7:0] data;
        logic       remote;
        logic       fin;
    } beat_t;

    // Terminal type answer, first byte in the top bits: IAC SB TTYPE IS "ANSI" IAC SE.
    localparam logic [79:0] TTYPE_ANSWER =
        {IAC_BYTE, CMD_SB, OPT_TTYPE, 8'd0, "ANSI", IAC_BYTE, CMD_SE};

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       to_remote;
    logic       last;

    // Idle rates in percent, and the long receiver hold-off flag.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic rx_hold       = 1'b0;

    int   sent_cnt = 0;
    int   err_cnt  = 0;

    // Predicted decoder state and the bytes still owed by the block, oldest first.
    phase_t     neg_phase = PH_DATA;
    logic [7:0] neg_cmd   = 8'd0;
    beat_t      owed_bytes[$];

    telnet_option_responder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .to_remote (to_remote),
        .last      (last)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Negotiation predictor: advance the decoder state by one received byte
    // and queue every byte the block must emit for it.
    // ------------------------------------------------------------------
    task automatic owe_reply(input logic [7:0] verb, input logic [7:0] opt);
        owed_bytes.push_back('{data: IAC_BYTE, remote: 1'b1, fin: 1'b0});
        owed_bytes.push_back('{data: verb,     remote: 1'b1, fin: 1'b0});
        owed_bytes.push_back('{data: opt,      remote: 1'b1, fin: 1'b1});
    endtask

    task automatic owe_ttype_answer();
        for (int k = 0; k < 10; k++)
            owed_bytes.push_back('{data: TTYPE_ANSWER[79 - 8*k -: 8], remote: 1'b1,
                                   fin: (k == 9)});
    endtask

    task automatic predict_replies(input logic [7:0] b);
        logic will_wont;
        logic do_dont;
        will_wont = (neg_cmd == CMD_WILL) || (neg_cmd == CMD_WONT);
        do_dont   = (neg_cmd == CMD_DO)   || (neg_cmd == CMD_DONT);
        case (neg_phase)
            PH_DATA:
                if (b == IAC_BYTE)
                    neg_phase = PH_CMD;
                else
                    owed_bytes.push_back('{data: b, remote: 1'b0, fin: 1'b1});
            PH_CMD:
            begin
                neg_cmd   = b;
                neg_phase = PH_OPT;
            end
            PH_OPT:
            begin
                neg_phase = PH_DATA;
                if (neg_cmd == CMD_DO && (b == OPT_SGA || b == OPT_TTYPE))
                    owe_reply(CMD_WILL, b);
                else if (will_wont && (b == OPT_ECHO || b == OPT_SGA || b == OPT_TTYPE))
                    owe_reply(CMD_DO, b);
                else if (will_wont)
                    owe_reply(CMD_DONT, b);
                else if (do_dont)
                    owe_reply(CMD_WONT, b);
                else if (neg_cmd == CMD_SB)
                begin
                    if (b == CMD_SE)
                        owe_ttype_answer();
                    else
                        neg_phase = PH_SKIP;
                end
                // any other command is dropped with its option byte
            end
            default:
                if (b == CMD_SE)
                begin
                    neg_phase = PH_DATA;
                    owe_ttype_answer();
                end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender: idle at random, then offer one byte and hold it until the
    // block takes it. Lower valid only in idle cycles so that back-to-back
    // items never see two assignments to in_valid in one time step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predict_replies(b);
        sent_cnt++;
    endtask

    task automatic send_command(input logic [7:0] cmd, input logic [7:0] opt);
        send_byte(IAC_BYTE);
        send_byte(cmd);
        send_byte(opt);
    endtask

    // Option byte biased toward the ones the block treats specially.
    function automatic logic [7:0] pick_option();
        case ($urandom_range(3))
            0:       return OPT_ECHO;
            1:       return OPT_SGA;
            2:       return OPT_TTYPE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Any byte but SE, so a subnegotiation body keeps the block skipping.
    function automatic logic [7:0] pick_sb_filler();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CMD_SE);
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: drop ready at the chosen rate, and hold it low for the
    // whole of a requested hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);

    // ------------------------------------------------------------------
    // Checker: compare every byte taken from the block with the oldest
    // owed byte, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_out
        beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_bytes.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected output: byte %0d remote %0b last %0b",
                             out_byte, to_remote, last);
            end
            else
            begin
                want = owed_bytes.pop_front();
                if (out_byte !== want.data || to_remote !== want.remote ||
                    last !== want.fin)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: want byte %0d remote %0b last %0b, got %0d %0b %0b",
                                 want.data, want.remote, want.fin,
                                 out_byte, to_remote, last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain bytes at both ends, every reply kind, an immediate and a skipped
    // subnegotiation, a doubled IAC and an unknown command.
    task automatic test_commands();
        send_byte(8'd0);
        send_byte(8'd254);
        send_command(CMD_DO, OPT_TTYPE);
        send_command(CMD_WILL, OPT_ECHO);
        send_command(CMD_WONT, 8'd255);
        send_command(CMD_DONT, OPT_SGA);
        send_command(CMD_SB, CMD_SE);
        send_command(CMD_SB, 8'd0);
        send_byte(CMD_SE);
        send_command(IAC_BYTE, 8'd255);
        send_command(8'd7, OPT_ECHO);
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering; the block must fill up and stall its input without loss.
    task automatic test_full_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                @(posedge clk);
                rx_hold <= 1'b1;
                repeat (120) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (8)
        begin
            send_command(CMD_SB, CMD_SE);
            send_byte(8'($urandom_range(254)));
            send_command(CMD_DO, pick_option());
        end
    endtask

    // Mostly well-formed negotiation traffic with random content, the rest
    // unknown commands, doubled IACs and raw noise.
    task automatic test_random_stream(input int tx_idle, input int rx_idle, input int n);
        int stop_at;
        int sel;
        stop_at       = sent_cnt + n;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        while (sent_cnt < stop_at)
        begin
            sel = $urandom_range(99);
            if (sel < 30)
                send_byte(8'($urandom_range(254)));
            else if (sel < 65)
                send_command(8'(CMD_WILL + $urandom_range(3)), pick_option());
            else if (sel < 80)
            begin
                send_byte(IAC_BYTE);
                send_byte(CMD_SB);
                repeat ($urandom_range(4))
                    send_byte(pick_sb_filler());
                send_byte(CMD_SE);
            end
            else if (sel < 88)
                send_command(8'($urandom_range(255)), 8'($urandom_range(255)));
            else if (sel < 92)
                send_command(IAC_BYTE, 8'($urandom_range(255)));
            else
                send_byte(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_commands();
        test_random_stream(25, 81, 120);
        test_random_stream(81, 25, 120);
        test_random_stream(0, 0, 120);
        test_full_stall();

        in_valid <= 1'b0;
        while (owed_bytes.size() != 0)
            @(posedge clk);
        // catch any stray byte after the last owed one
        repeat (30) @(posedge clk);

        if (err_cnt == 0)
            $display("[telnet_option_responder_top] OK");
        else
            $display("[telnet_option_responder_top] ERROR");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #4000000;
        $display("[telnet_option_responder_top] ERROR");
        $finish;
    end

endmodule
